[rtl/core/lrl_pkg.sv]
// ----------------------------------------------------------------------------
// lrl_pkg: shared codes and types for the LRU recency list
// Opcode and status codes and the packed result beat handed to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lrl_pkg;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADIDX   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] popped_value;
        logic [3:0]  found_index;
        logic [4:0]  list_size;
        logic        is_empty;
        logic        is_full;
    } res_t;

endpackage

`default_nettype wire

[rtl/core/lrl_store.sv]
// ----------------------------------------------------------------------------
// lrl_store: entry memory of the LRU recency list
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lrl_store #(
    parameter int DEPTH = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [63:0]                wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [63:0]                rd_data
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/lrl_ctrl.sv]
// ----------------------------------------------------------------------------
// lrl_ctrl: sequencer of the LRU recency list
// Decodes one beat, walks the memory for pop and find, holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lrl_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 in_opcode,
    input  wire logic [63:0]                in_value,
    input  wire logic [3:0]                 in_index,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output lrl_pkg::res_t                   res,
    output logic                            wr_en,
    output logic      [$clog2(DEPTH)-1:0]   wr_addr,
    output logic      [63:0]                wr_data,
    output logic                            rd_en,
    output logic      [$clog2(DEPTH)-1:0]   rd_addr,
    input  wire logic [63:0]                rd_data
);
    import lrl_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    state_reg,  state_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [CW-1:0] ptr_reg,    ptr_next;
    logic          first_reg,  first_next;
    logic [63:0]   value_reg,  value_next;
    logic [1:0]    status_reg, status_next;
    logic [63:0]   popped_reg, popped_next;
    logic [3:0]    found_reg,  found_next;
    logic          out_valid_reg, out_valid_next;
    res_t          out_reg,    out_next;

    logic          accept;
    logic          more;
    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] ptr_dec;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign ptr_inc  = ptr_reg + 1'b1;
    assign ptr_dec  = ptr_reg - 1'b1;
    assign more     = ptr_inc < count_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        first_next     = first_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = in_value;
        rd_en          = 1'b0;
        rd_addr        = ptr_inc[AW-1:0];

        if (out_valid_reg && res_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    value_next  = in_value;
                    status_next = ST_OK;
                    popped_next = '0;
                    found_next  = '0;
                    state_next  = S_DONE;
                    case (in_opcode)
                        OP_PUSH: begin
                            if (count_reg == CW'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (CMPW'(in_index) >= CMPW'(count_reg)) begin
                                status_next = ST_BADIDX;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(in_index);
                                ptr_next   = CW'(in_index);
                                first_next = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        OP_FIND: begin
                            if (count_reg == '0) begin
                                status_next = ST_NOTFOUND;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                ptr_next   = '0;
                                state_next = S_FIND;
                            end
                        end
                        default: begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            S_POP: begin
                // rd_data holds the entry at ptr; keep the first as popped, move later ones down one slot.
                if (first_reg) begin
                    popped_next = rd_data;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = ptr_dec[AW-1:0];
                    wr_data = rd_data;
                end
                first_next = 1'b0;
                if (more) begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_inc;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_FIND: begin
                if (rd_data == value_reg) begin
                    found_next = 4'(ptr_reg);
                    state_next = S_DONE;
                end else if (more) begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_inc;
                end else begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || res_ready) begin
                    out_valid_next        = 1'b1;
                    out_next.status       = status_reg;
                    out_next.popped_value = popped_reg;
                    out_next.found_index  = found_reg;
                    out_next.list_size    = 5'(count_reg);
                    out_next.is_empty     = (count_reg == '0);
                    out_next.is_full      = (count_reg == CW'(DEPTH));
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        first_reg  <= first_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
        found_reg  <= found_next;
        out_reg    <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

[rtl/core/lru_recency_list.sv]
// ----------------------------------------------------------------------------
// lru_recency_list: ordered recency list of 64-bit page entries
// Push, pop at position, find and clear over a list held in one memory.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Ports
//   s_       in         s_valid, s_ready, s_opcode, s_entry_value, s_entry_index
//   m_       out        m_valid, m_ready, m_status, m_popped_value, m_found_index,
//                       m_list_size, m_is_empty, m_is_full
//
// One beat is worked on at a time; push and clear need no memory read, pop at
// index i first reads each entry from i to the end of the list, and find reads
// from slot 0 up to the match, one memory read per entry. Reset clears the
// sequencer, the entry count and the result valid, never the memory. A stalled
// result holds its register while the next beat is worked on, which then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_recency_list #(
    parameter int DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [63:0] s_entry_value,
    input  wire logic [3:0]  s_entry_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [1:0]  m_status,
    output logic      [63:0] m_popped_value,
    output logic      [3:0]  m_found_index,
    output logic      [4:0]  m_list_size,
    output logic             m_is_empty,
    output logic             m_is_full
);
    import lrl_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // Memory port between the sequencer and the entry store.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data;

    res_t          res;

    // The sequencer owns the entry count and the result register. Pop reads the
    // entry at the index, then streams each later entry one slot down: the read
    // of slot p+1 is issued in the same cycle as the write of slot p-1, so the
    // two ports never touch the same entry and no forwarding is needed.
    lrl_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_opcode (s_opcode),
        .in_value  (s_entry_value),
        .in_index  (s_entry_index),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // Entries below the count have always been written; nothing above it is read.
    lrl_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_status       = res.status;
    assign m_popped_value = res.popped_value;
    assign m_found_index  = res.found_index;
    assign m_list_size    = res.list_size;
    assign m_is_empty     = res.is_empty;
    assign m_is_full      = res.is_full;

`ifndef SYNTHESIS
    // The engine takes one beat at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a beat is in progress");

    // The empty flag agrees with the reported size.
    a_empty_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_list_size == 5'd0)))
        else $error("empty flag disagrees with list size");

    // A full report only comes from a list that is full.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_FULL)) |-> m_is_full)
        else $error("full status on a list that is not full");

    // A popped value or a found position only appears on a successful beat.
    a_payload_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_popped_value != 64'd0) || (m_found_index != 4'd0)))
            |-> (m_status == ST_OK))
        else $error("payload set on a failed beat");
`endif

endmodule

`default_nettype wire
